// ----- rtl/tuvg_pkg.sv -----
// ----------------------------------------------------------------------------
// tuvg_pkg: shared types and constants of the version-1 UUID generator
// Holds the register map, the record passed from the front end to the back
// end, the result record and the fixed UUID constants.
// ----------------------------------------------------------------------------
package tuvg_pkg;

  localparam int SEC_W  = 34;
  localparam int USEC_W = 20;
  localparam int SEQ_W  = 13;
  localparam int ADJ_W  = 4;
  localparam int NODE_W = 48;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;

  // Register index, taken from paddr[4:3].
  localparam logic [1:0] REG_NODE_ID    = 2'd0;
  localparam logic [1:0] REG_INIT_SEQ   = 2'd1;
  localparam logic [1:0] REG_MAX_ADJUST = 2'd2;

  localparam logic [ADJ_W-1:0]  MAX_ADJ_RESET  = 4'd10;
  localparam logic [23:0]       TICKS_PER_SEC  = 24'd10000000;
  localparam logic [63:0]       EPOCH_OFFSET   = 64'h01B2_1DD2_1381_4000;
  localparam logic [15:0]       VERSION_BITS   = 16'h1000;
  localparam logic [15:0]       VARIANT_BIT    = 16'h8000;
  localparam logic [NODE_W-1:0] NODE_MULTICAST = 48'h8000_0000_0000;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF   = 2;

  typedef struct packed {
    logic [NODE_W-1:0] node_id;
    logic [SEQ_W-1:0]  initial_sequence;
    logic [ADJ_W-1:0]  adj_limit;
  } cfg_t;

  // Classified reading, as left by the front end.
  typedef struct packed {
    logic              retry;
    logic [SEC_W-1:0]  seconds;
    logic [USEC_W-1:0] microseconds;
    logic [ADJ_W-1:0]  adjustment;
    logic [SEQ_W-1:0]  seq;
  } rec_t;

  typedef struct packed {
    logic              status;
    logic [31:0]       ts_low;
    logic [15:0]       ts_mid;
    logic [15:0]       time_high_version;
    logic [15:0]       sequence_field;
    logic [NODE_W-1:0] node_field;
  } res_t;

endpackage

// ----- rtl/tuvg_fifo.sv -----
// ----------------------------------------------------------------------------
// tuvg_fifo: small synchronous queue
// Register-based first-in first-out store with full and empty flags.
// ----------------------------------------------------------------------------
module tuvg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/tuvg_regs.sv -----
// ----------------------------------------------------------------------------
// tuvg_regs: configuration registers
// APB-style register file holding the node identifier, the initial clock
// sequence and the adjustment limit.
// ----------------------------------------------------------------------------
module tuvg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tuvg_pkg::PADDR_W-1:0] paddr,
  input  logic [tuvg_pkg::PDATA_W-1:0] pwdata,
  output logic [tuvg_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output tuvg_pkg::cfg_t               cfg
);

  tuvg_pkg::cfg_t cfg_r, cfg_nxt;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = '0;
    case (reg_idx)
      tuvg_pkg::REG_NODE_ID: begin
        prdata = {16'b0, cfg_r.node_id};
        if (wr_en) cfg_nxt.node_id = pwdata[tuvg_pkg::NODE_W-1:0];
      end
      tuvg_pkg::REG_INIT_SEQ: begin
        prdata = {51'b0, cfg_r.initial_sequence};
        if (wr_en) cfg_nxt.initial_sequence = pwdata[tuvg_pkg::SEQ_W-1:0];
      end
      tuvg_pkg::REG_MAX_ADJUST: begin
        prdata = {60'b0, cfg_r.adj_limit};
        if (wr_en) cfg_nxt.adj_limit = pwdata[tuvg_pkg::ADJ_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_id          <= '0;
      cfg_r.initial_sequence <= '0;
      cfg_r.adj_limit        <= tuvg_pkg::MAX_ADJ_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/tuvg_front.sv -----
// ----------------------------------------------------------------------------
// tuvg_front: reading classifier and clock-sequence state
// Compares each accepted reading with the last recorded one, updates the
// sequence and adjustment and hands a classified record to the queue.
// ----------------------------------------------------------------------------
module tuvg_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic                        q_full,
  input  logic [tuvg_pkg::SEC_W-1:0]  in_seconds,
  input  logic [tuvg_pkg::USEC_W-1:0] in_microseconds,
  input  tuvg_pkg::cfg_t              cfg,
  output tuvg_pkg::rec_t              rec,
  output logic                        rec_push
);

  logic                        started_r, started_nxt;
  logic [tuvg_pkg::SEC_W-1:0]  last_sec_r, last_sec_nxt;
  logic [tuvg_pkg::USEC_W-1:0] last_usec_r, last_usec_nxt;
  logic [tuvg_pkg::ADJ_W-1:0]  adj_r, adj_nxt;
  logic [tuvg_pkg::SEQ_W-1:0]  seq_r, seq_nxt;
  logic                        sec_eq, earlier, equal, retry;

  assign rec_push = push && !q_full;
  assign sec_eq   = (in_seconds == last_sec_r);
  assign earlier  = (in_seconds < last_sec_r) || (sec_eq && in_microseconds < last_usec_r);
  assign equal    = sec_eq && (in_microseconds == last_usec_r);
  assign retry    = started_r && equal && (adj_r >= cfg.adj_limit);

  always_comb begin
    started_nxt   = started_r;
    last_sec_nxt  = last_sec_r;
    last_usec_nxt = last_usec_r;
    adj_nxt       = adj_r;
    seq_nxt       = seq_r;
    if (!started_r) begin
      started_nxt   = 1'b1;
      seq_nxt       = cfg.initial_sequence;
      adj_nxt       = '0;
      last_sec_nxt  = in_seconds;
      last_usec_nxt = in_microseconds;
    end else if (earlier) begin
      seq_nxt       = seq_r + 1'b1;
      adj_nxt       = '0;
      last_sec_nxt  = in_seconds;
      last_usec_nxt = in_microseconds;
    end else if (equal) begin
      // At the limit nothing changes and the transaction reports a retry.
      if (!retry) adj_nxt = adj_r + 1'b1;
    end else begin
      adj_nxt       = '0;
      last_sec_nxt  = in_seconds;
      last_usec_nxt = in_microseconds;
    end
  end

  always_comb begin
    rec.retry        = retry;
    rec.seconds      = in_seconds;
    rec.microseconds = in_microseconds;
    rec.adjustment   = adj_nxt;
    rec.seq          = seq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      last_sec_r  <= '0;
      last_usec_r <= '0;
      adj_r       <= '0;
      seq_r       <= '0;
    end else if (rec_push) begin
      started_r   <= started_nxt;
      last_sec_r  <= last_sec_nxt;
      last_usec_r <= last_usec_nxt;
      adj_r       <= adj_nxt;
      seq_r       <= seq_nxt;
    end
  end

endmodule

// ----- rtl/tuvg_back.sv -----
// ----------------------------------------------------------------------------
// tuvg_back: timestamp pipeline
// Two-stage pipeline that turns a classified record into the UUID fields:
// partial products of the seconds first, then the 64-bit sum.
// ----------------------------------------------------------------------------
module tuvg_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tuvg_pkg::rec_t              q_rec,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  logic [tuvg_pkg::NODE_W-1:0] node_id,
  output tuvg_pkg::res_t              res,
  output logic                        res_push,
  input  logic                        res_full
);

  logic                       s1_v_r;
  logic                       s1_retry_r;
  logic [tuvg_pkg::SEQ_W-1:0] s1_seq_r;
  logic [40:0]                s1_phi_r, s1_plo_r;
  logic [24:0]                s1_base_r;
  logic                       s2_v_r;
  tuvg_pkg::res_t             s2_res_r, s2_res_nxt;
  logic                       s1_ready, s2_ready;
  logic [40:0]                phi_nxt, plo_nxt;
  logic [24:0]                base_nxt;
  logic [63:0]                ts;

  assign s2_ready = !s2_v_r || !res_full;
  assign s1_ready = !s1_v_r || s2_ready;
  assign q_pop    = !q_empty && s1_ready;
  assign res_push = s2_v_r;
  assign res      = s2_res_r;

  // The 34-bit seconds are split in halves of 17 bits to keep each product narrow.
  assign phi_nxt  = {24'b0, q_rec.seconds[33:17]} * {17'b0, tuvg_pkg::TICKS_PER_SEC};
  assign plo_nxt  = {24'b0, q_rec.seconds[16:0]} * {17'b0, tuvg_pkg::TICKS_PER_SEC};
  assign base_nxt = {2'b0, q_rec.microseconds, 3'b0} + {4'b0, q_rec.microseconds, 1'b0}
                  + {21'b0, q_rec.adjustment};

  assign ts = {6'b0, s1_phi_r, 17'b0} + {23'b0, s1_plo_r} + {39'b0, s1_base_r}
            + tuvg_pkg::EPOCH_OFFSET;

  always_comb begin
    if (s1_retry_r) begin
      s2_res_nxt        = '0;
      s2_res_nxt.status = 1'b1;
    end else begin
      s2_res_nxt.status            = 1'b0;
      s2_res_nxt.ts_low            = ts[31:0];
      s2_res_nxt.ts_mid            = ts[47:32];
      s2_res_nxt.time_high_version = ts[63:48] | tuvg_pkg::VERSION_BITS;
      s2_res_nxt.sequence_field    = {3'b0, s1_seq_r} | tuvg_pkg::VARIANT_BIT;
      s2_res_nxt.node_field        = node_id | tuvg_pkg::NODE_MULTICAST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= !q_empty;
      if (s2_ready) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_retry_r <= q_rec.retry;
      s1_seq_r   <= q_rec.seq;
      s1_phi_r   <= phi_nxt;
      s1_plo_r   <= plo_nxt;
      s1_base_r  <= base_nxt;
    end
    if (s2_ready && s1_v_r) begin
      s2_res_r <= s2_res_nxt;
    end
  end

endmodule

// ----- rtl/time_based_uuid_generator_core.sv -----
// ----------------------------------------------------------------------------
// time_based_uuid_generator_core: version-1 UUID generator
// Turns time readings into time-based UUIDs with a retry status.
// ----------------------------------------------------------------------------
// Readings enter through a queue-style port: seconds and microseconds are
// taken at an edge where push is high and full is low. Results leave through
// a queue-style port: while empty is low the oldest result is on the out_
// ports and it is taken at an edge where pop is high.
// The front end classifies each reading and updates the clock sequence in
// the cycle of its transaction, so one reading is accepted every cycle
// while full is low. A short queue feeds a two-stage timestamp pipeline,
// whose width is set by the 64-bit sum of the split seconds products,
// and one result leaves per cycle while pop is high and empty is low.
// When pop stays low the output queue fills, the pipeline and the input
// queue back up and full rises; nothing is lost. Reset clears the queues,
// the pipeline and the sequence state; the next reading is treated as the
// first. Registers sit at byte addresses 0, 8 and 16; the user must write
// them only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module time_based_uuid_generator_core #(
  parameter int QUEUE_DEPTH = tuvg_pkg::QUEUE_DEPTH_DEF,
  parameter int OUT_DEPTH   = tuvg_pkg::OUT_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [tuvg_pkg::SEC_W-1:0]   in_seconds,
  input  logic [tuvg_pkg::USEC_W-1:0]  in_microseconds,
  output logic                         empty,
  input  logic                         pop,
  output logic                         out_status,
  output logic [31:0]                  out_ts_low,
  output logic [15:0]                  out_ts_mid,
  output logic [15:0]                  out_time_high_version,
  output logic [15:0]                  out_sequence_field,
  output logic [tuvg_pkg::NODE_W-1:0]  out_node_field,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tuvg_pkg::PADDR_W-1:0] paddr,
  input  logic [tuvg_pkg::PDATA_W-1:0] pwdata,
  output logic [tuvg_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  tuvg_pkg::cfg_t cfg;
  tuvg_pkg::rec_t front_rec, q_rec;
  tuvg_pkg::res_t back_res, out_res;
  logic           rec_push, q_full, q_empty, q_pop;
  logic           res_push, res_full;

  tuvg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tuvg_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .q_full          (q_full),
    .in_seconds      (in_seconds),
    .in_microseconds (in_microseconds),
    .cfg             (cfg),
    .rec             (front_rec),
    .rec_push        (rec_push)
  );

  tuvg_fifo #(
    .WIDTH ($bits(tuvg_pkg::rec_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .wdata (front_rec),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rec),
    .empty (q_empty)
  );

  tuvg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_rec    (q_rec),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .node_id  (cfg.node_id),
    .res      (back_res),
    .res_push (res_push),
    .res_full (res_full)
  );

  tuvg_fifo #(
    .WIDTH ($bits(tuvg_pkg::res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign full                  = q_full;
  assign out_status            = out_res.status;
  assign out_ts_low            = out_res.ts_low;
  assign out_ts_mid            = out_res.ts_mid;
  assign out_time_high_version = out_res.time_high_version;
  assign out_sequence_field    = out_res.sequence_field;
  assign out_node_field        = out_res.node_field;

endmodule

// ----- rtl/tuvg_checker.sv -----
// ----------------------------------------------------------------------------
// tuvg_checker: port-level checks for the UUID generator
// Watches the result channel and attaches itself to the top level.
// ----------------------------------------------------------------------------
module tuvg_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        empty,
  input logic                        pop,
  input logic                        out_status,
  input logic [31:0]                 out_ts_low,
  input logic [15:0]                 out_ts_mid,
  input logic [15:0]                 out_time_high_version,
  input logic [15:0]                 out_sequence_field,
  input logic [tuvg_pkg::NODE_W-1:0] out_node_field
);

  // After reset no result may be offered.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result offered straight after reset");

  // A retry transaction carries all-zero fields.
  a_retry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status) |-> (out_ts_low == '0 && out_ts_mid == '0 &&
      out_time_high_version == '0 && out_sequence_field == '0 && out_node_field == '0))
    else $error("retry transaction with non-zero fields");

  // A produced UUID carries version, variant and multicast marks.
  a_uuid_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_status) |-> (out_time_high_version[15:12] == 4'h1 &&
      out_sequence_field[15:13] == 3'b100 && out_node_field[47]))
    else $error("UUID without version, variant or multicast bits");

  // A result that is not taken stays on the ports.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_ts_low) && $stable(out_status) &&
      $stable(out_sequence_field)))
    else $error("stalled result changed");

endmodule

bind time_based_uuid_generator_core tuvg_checker u_tuvg_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .empty                 (empty),
  .pop                   (pop),
  .out_status            (out_status),
  .out_ts_low            (out_ts_low),
  .out_ts_mid            (out_ts_mid),
  .out_time_high_version (out_time_high_version),
  .out_sequence_field    (out_sequence_field),
  .out_node_field        (out_node_field)
);

// ----- verif/time_based_uuid_generator_core_tb.sv -----
// ----------------------------------------------------------------------------
// time_based_uuid_generator_core_tb: self-checking bench for the UUID core
// Drives time readings through the input queue port and checks every UUID
// against a cycle-free model of the clock sequence and adjustment logic.
// Registers are programmed over the APB-style port between phases and read
// back. Both handshakes idle at random, apart from one steady phase.
// ----------------------------------------------------------------------------
module time_based_uuid_generator_core_tb;

  import tuvg_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 300;
  localparam int RANDOM_PHASES = 5;
  localparam int DRAIN_CYCLES = 8;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [SEC_W-1:0]    in_seconds = '0;
  logic [USEC_W-1:0]   in_microseconds = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic                out_status;
  logic [31:0]         out_ts_low;
  logic [15:0]         out_ts_mid;
  logic [15:0]         out_time_high_version;
  logic [15:0]         out_sequence_field;
  logic [NODE_W-1:0]   out_node_field;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Register shadow copies.
  logic [NODE_W-1:0]   cfg_node_id = '0;
  logic [SEQ_W-1:0]    cfg_init_seq = '0;
  logic [ADJ_W-1:0]    cfg_max_adj = MAX_ADJ_RESET;

  // Clock sequence state as the block should hold it.
  logic                seq_started = 1'b0;
  logic [SEC_W-1:0]    last_sec = '0;
  logic [USEC_W-1:0]   last_usec = '0;
  logic [ADJ_W-1:0]    adj_count = '0;
  logic [SEQ_W-1:0]    seq_model = '0;

  // Last reading handed to the block, used to build related readings.
  logic [SEC_W-1:0]    sent_sec = '0;
  logic [USEC_W-1:0]   sent_usec = '0;

  res_t                uuid_expected[$];
  int                  mismatches = 0;
  int                  cycle_count = 0;
  bit                  no_idling = 1'b0;

  time_based_uuid_generator_core u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .push                  (push),
    .full                  (full),
    .in_seconds            (in_seconds),
    .in_microseconds       (in_microseconds),
    .empty                 (empty),
    .pop                   (pop),
    .out_status            (out_status),
    .out_ts_low            (out_ts_low),
    .out_ts_mid            (out_ts_mid),
    .out_time_high_version (out_time_high_version),
    .out_sequence_field    (out_sequence_field),
    .out_node_field        (out_node_field),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Computes the UUID for one accepted reading and advances the state.
  function automatic res_t predict_uuid(input logic [SEC_W-1:0] sec,
                                        input logic [USEC_W-1:0] usec);
    res_t        r;
    logic [63:0] ts;
    r = '0;
    if (!seq_started) begin
      seq_started = 1'b1;
      seq_model   = cfg_init_seq;
      adj_count   = '0;
      last_sec    = sec;
      last_usec   = usec;
    end else if (sec < last_sec || (sec == last_sec && usec < last_usec)) begin
      seq_model = seq_model + 1'b1;
      adj_count = '0;
      last_sec  = sec;
      last_usec = usec;
    end else if (sec == last_sec && usec == last_usec) begin
      if (adj_count >= cfg_max_adj) begin
        r.status = 1'b1;
        return r;
      end
      adj_count = adj_count + 1'b1;
    end else begin
      adj_count = '0;
      last_sec  = sec;
      last_usec = usec;
    end
    ts = 64'(usec) * 64'd10 + 64'(adj_count) + 64'(sec) * 64'(TICKS_PER_SEC)
         + EPOCH_OFFSET;
    r.ts_low            = ts[31:0];
    r.ts_mid            = ts[47:32];
    r.time_high_version = ts[63:48] | VERSION_BITS;
    r.sequence_field    = 16'(seq_model) | VARIANT_BIT;
    r.node_field        = cfg_node_id | NODE_MULTICAST;
    return r;
  endfunction

  task automatic send_reading(input logic [SEC_W-1:0] sec,
                              input logic [USEC_W-1:0] usec);
    while (!no_idling && $urandom_range(99) < 32) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push            <= 1'b1;
    in_seconds      <= sec;
    in_microseconds <= usec;
    @(posedge clk);
    while (full) @(posedge clk);
    uuid_expected.push_back(predict_uuid(sec, usec));
    sent_sec  = sec;
    sent_usec = usec;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (uuid_expected.size() != 0) @(posedge clk);
  endtask

  // Writes one register, reads it back and updates the shadow copy.
  task automatic write_register(input logic [1:0] reg_idx,
                                input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] masked;
    case (reg_idx)
      REG_NODE_ID:  masked = PDATA_W'(value[NODE_W-1:0]);
      REG_INIT_SEQ: masked = PDATA_W'(value[SEQ_W-1:0]);
      default:      masked = PDATA_W'(value[ADJ_W-1:0]);
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== masked) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d read back: expected %h, got %h", reg_idx, masked, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    case (reg_idx)
      REG_NODE_ID:  cfg_node_id  = value[NODE_W-1:0];
      REG_INIT_SEQ: cfg_init_seq = value[SEQ_W-1:0];
      default:      cfg_max_adj  = value[ADJ_W-1:0];
    endcase
    @(posedge clk);
  endtask

  // Result side: random back-pressure and the comparison of each transaction.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= no_idling || ($urandom_range(99) >= 32);
    end
    if (rst_n && pop && !empty) begin
      got = '{out_status, out_ts_low, out_ts_mid, out_time_high_version,
              out_sequence_field, out_node_field};
      if (uuid_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: %p", got);
      end else begin
        want = uuid_expected.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("UUID mismatch at cycle %0d", cycle_count);
            $display("  status   exp %h got %h", want.status, got.status);
            $display("  ts_low   exp %h got %h", want.ts_low, got.ts_low);
            $display("  ts_mid   exp %h got %h", want.ts_mid, got.ts_mid);
            $display("  time_hi  exp %h got %h", want.time_high_version,
                     got.time_high_version);
            $display("  sequence exp %h got %h", want.sequence_field,
                     got.sequence_field);
            $display("  node     exp %h got %h", want.node_field, got.node_field);
          end
        end
      end
    end
  end

  // First reading loads the sequence, repeats run into the retry status and
  // an earlier reading wraps the sequence from its top value to zero.
  task automatic test_first_reading();
    write_register(REG_NODE_ID, 64'h0);
    write_register(REG_INIT_SEQ, 64'h1FFF);
    write_register(REG_MAX_ADJUST, 64'h2);
    send_reading(34'd1700000000, 20'd500000);
    send_reading(34'd1700000000, 20'd500000);
    send_reading(34'd1700000000, 20'd500000);
    send_reading(34'd1700000000, 20'd500000);
    send_reading(34'd1700000000, 20'd500000);
    send_reading(34'd1700000000, 20'd500001);
    send_reading(34'd1699999999, 20'd999999);
    wait_drained();
  endtask

  // Field extremes, microseconds past one second and a zero adjustment limit.
  task automatic test_extreme_readings();
    write_register(REG_NODE_ID, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(REG_INIT_SEQ, 64'h0);
    write_register(REG_MAX_ADJUST, 64'h0);
    send_reading('1, '1);
    send_reading('1, '1);
    send_reading('0, '0);
    send_reading('0, '1);
    send_reading(34'd1, 20'd0);
    send_reading(34'd1, 20'd0);
    wait_drained();
  endtask

  // The widest adjustment limit is used up in full before the retry.
  task automatic test_adjustment_limit();
    write_register(REG_NODE_ID, 64'h0000_5A5A_5A5A_5A5A);
    write_register(REG_MAX_ADJUST, 64'hF);
    send_reading(34'd2, 20'd3);
    repeat (16) send_reading(34'd2, 20'd3);
    wait_drained();
  endtask

  // Mostly readings related to the previous one: repeats, small steps back
  // and small steps forward dominate; the rest has full-range microseconds.
  task automatic test_random_readings();
    logic [SEC_W-1:0]  sec;
    logic [USEC_W-1:0] usec;
    int                pick;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_register(REG_NODE_ID, (phase == 3) ? 64'h0 : {$urandom, $urandom});
      write_register(REG_INIT_SEQ, {$urandom, $urandom});
      case (phase)
        1:       write_register(REG_MAX_ADJUST, 64'h0);
        2:       write_register(REG_MAX_ADJUST, 64'hF);
        default: write_register(REG_MAX_ADJUST, 64'($urandom_range(15)));
      endcase
      no_idling = (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        sec  = sent_sec;
        usec = sent_usec;
        if (pick < 35) begin
          // Repeat of the previous reading.
        end else if (pick < 55) begin
          if ($urandom_range(1)) usec = sent_usec + USEC_W'($urandom_range(3, 1));
          else sec = sent_sec + 1'b1;
        end else if (pick < 70) begin
          if ($urandom_range(1)) usec = sent_usec - USEC_W'($urandom_range(3, 1));
          else sec = sent_sec - 1'b1;
        end else if (pick < 85) begin
          sec  = sent_sec + SEC_W'($urandom_range(2)) - SEC_W'($urandom_range(2));
          usec = USEC_W'($urandom);
        end else begin
          sec  = {2'($urandom_range(3)), 32'($urandom)};
          usec = USEC_W'($urandom);
        end
        send_reading(sec, usec);
      end
      wait_drained();
      no_idling = 1'b0;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_reading();
    test_extreme_readings();
    test_adjustment_limit();
    test_random_readings();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && uuid_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
